@@ sv/priority_heap_queue_assert.svh @@
// Assertion macros for the priority heap queue.
// Included by the top level; no other dependencies.
`ifndef PRIORITY_HEAP_QUEUE_ASSERT_SVH
`define PRIORITY_HEAP_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PHQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define PHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/phq_pkg.sv @@
// Shared types and constants for the priority heap queue.
// No dependencies.
`default_nettype none
package phq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    localparam int ID_W   = 8;
    localparam int PORT_W = 32;
    localparam int OCC_W  = 7;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_EDF  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] arrival;
        logic [PORT_W-1:0] deadline;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage
`default_nettype wire

@@ sv/phq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module phq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/phq_out_reg.sv @@
// Output result register between the sift engine and the output channel.
// Uses phq_pkg.
`default_nettype none
module phq_out_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ld_valid,
    input  wire phq_pkg::result_t ld_data,
    output logic                 ld_take,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output phq_pkg::result_t     out_data
);

    logic             valid_reg;
    logic             valid_next;
    phq_pkg::result_t data_reg;

    assign ld_take    = ld_valid && (!valid_reg || !out_stall);
    assign valid_next = ld_take || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_take)
        begin
            data_reg <= ld_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

@@ sv/phq_sift.sv @@
// Heap control: push with sift-up, pop with sift-down, over the slot RAM.
// Uses phq_pkg and phq_ram.
`default_nettype none
module phq_sift #(
    parameter int DEPTH     = phq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = phq_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        kind,
    input  wire logic [phq_pkg::ID_W-1:0]    request_id,
    input  wire logic [phq_pkg::PORT_W-1:0]  req_arrival,
    input  wire logic [phq_pkg::PORT_W-1:0]  deadline,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output phq_pkg::result_t                 res_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int TB = TIME_BITS;
    localparam int EW = phq_pkg::ID_W + 2 * TB;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

    function automatic logic precedes(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                      input logic mode);
        logic [TB-1:0] ka;
        logic [TB-1:0] kb;
        ka = (mode == phq_pkg::MODE_EDF) ? a[TB-1:0] : a[2*TB-1:TB];
        kb = (mode == phq_pkg::MODE_EDF) ? b[TB-1:0] : b[2*TB-1:TB];
        return ka < kb;
    endfunction

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        logic [AW-1:0] d;
        d = p - AW'(1);
        return d >> 1;
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          mode_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] par_reg, par_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] best_reg, best_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          best_cur_reg, best_cur_next;
    logic          rvalid_reg, rvalid_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [EW-1:0] res_ent_reg, res_ent_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [IW-1:0] cnt_ext;
    logic [IW-1:0] left_idx;
    logic [IW-1:0] right_idx;
    logic [IW-1:0] next_left;
    logic [EW-1:0] fin_ent;
    logic [AW-1:0] fin_idx;
    logic          fin_cur;

    phq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_ext   = IW'(count_reg);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);

    always_comb
    begin
        if (rvalid_reg && precedes(ram_rdata, best_reg, mode_reg))
        begin
            fin_ent = ram_rdata;
            fin_idx = right_idx[AW-1:0];
            fin_cur = 1'b0;
        end
        else
        begin
            fin_ent = best_reg;
            fin_idx = best_idx_reg;
            fin_cur = best_cur_reg;
        end
        next_left = {1'b0, fin_idx, 1'b1};
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        par_next        = par_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_cur_next   = best_cur_reg;
        rvalid_next     = rvalid_reg;
        res_status_next = res_status_reg;
        res_ent_next    = res_ent_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = '0;
        res_valid       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = phq_pkg::ST_DONE;
                    res_ent_next    = '0;
                    if (kind == phq_pkg::KIND_PUSH)
                    begin
                        if (count_reg >= CW'(DEPTH))
                        begin
                            res_status_next = phq_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cur_next   = {request_id, TB'(req_arrival), TB'(deadline)};
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = phq_pkg::ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = parent_of(pos_reg);
                    par_next   = parent_of(pos_reg);
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (precedes(cur_reg, ram_rdata, mode_reg))
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = par_reg;
                    if (par_reg != '0)
                    begin
                        ram_raddr = parent_of(par_reg);
                        par_next  = parent_of(par_reg);
                    end
                    else
                    begin
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_ROOT:
            begin
                res_ent_next = ram_rdata;
                ram_raddr    = count_reg[AW-1:0];
                state_next   = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (left_idx >= cnt_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                if (precedes(ram_rdata, cur_reg, mode_reg))
                begin
                    best_next     = ram_rdata;
                    best_idx_next = left_idx[AW-1:0];
                    best_cur_next = 1'b0;
                end
                else
                begin
                    best_next     = cur_reg;
                    best_idx_next = pos_reg;
                    best_cur_next = 1'b1;
                end
                rvalid_next = right_idx < cnt_ext;
                ram_raddr   = right_idx[AW-1:0];
                state_next  = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (fin_cur)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_wdata = fin_ent;
                    pos_next  = fin_idx;
                    if (next_left < cnt_ext)
                    begin
                        ram_raddr  = next_left[AW-1:0];
                        state_next = S_DN_R;
                    end
                    else
                    begin
                        state_next = S_DN_L;
                    end
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mode_reg  <= phq_pkg::MODE_FIFO;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        par_reg        <= par_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_cur_reg   <= best_cur_next;
        rvalid_reg     <= rvalid_next;
        res_status_reg <= res_status_next;
        res_ent_reg    <= res_ent_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        res_data.status    = res_status_reg;
        res_data.id        = res_ent_reg[EW-1:2*TB];
        res_data.arrival   = phq_pkg::PORT_W'(res_ent_reg[2*TB-1:TB]);
        res_data.deadline  = phq_pkg::PORT_W'(res_ent_reg[TB-1:0]);
        res_data.occupancy = phq_pkg::OCC_W'(count_reg);
    end

endmodule
`default_nettype wire

@@ sv/priority_heap_queue.sv @@
// Top level of the priority heap queue: sift engine and output register.
// Uses phq_pkg, phq_sift, phq_out_reg and priority_heap_queue_assert.svh.
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------------
//   cfg      cfg_we               cfg_data (order_mode)
//   in       in_valid / in_stall  kind, request_id, req_arrival, deadline
//   out      out_valid/out_stall  status, out_id, out_arrival, out_deadline, occupancy
//
// A full push or an empty pop only reports its status; a push into an empty queue
// writes the root. Otherwise a push reads and compares one parent per level moved up,
// and a pop reads the root, then the last entry, then compares the children of each
// level it moves down through; one RAM read port orders these reads.
// Reset clears the count and mode; slot contents are not cleared.
// A new item is taken while the previous result waits in the output register.
`default_nettype none
`include "priority_heap_queue_assert.svh"
module priority_heap_queue #(
    parameter int DEPTH     = phq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = phq_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        kind,
    input  wire logic [phq_pkg::ID_W-1:0]    request_id,
    input  wire logic [phq_pkg::PORT_W-1:0]  req_arrival,
    input  wire logic [phq_pkg::PORT_W-1:0]  deadline,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [phq_pkg::ID_W-1:0]         out_id,
    output logic [phq_pkg::PORT_W-1:0]       out_arrival,
    output logic [phq_pkg::PORT_W-1:0]       out_deadline,
    output logic [phq_pkg::OCC_W-1:0]        occupancy
);

    logic             res_valid;
    logic             res_take;
    phq_pkg::result_t res_data;
    phq_pkg::result_t out_data;

    phq_sift #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_sift (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .request_id   (request_id),
        .req_arrival  (req_arrival),
        .deadline     (deadline),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_data     (res_data)
    );

    phq_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_valid  (res_valid),
        .ld_data   (res_data),
        .ld_take   (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign out_id       = out_data.id;
    assign out_arrival  = out_data.arrival;
    assign out_deadline = out_data.deadline;
    assign occupancy    = out_data.occupancy;

    `PHQ_ASSERT(a_occ_bound, clk, rst_n, out_valid |-> (32'(occupancy) <= DEPTH), "occupancy above depth")
    `PHQ_ASSERT(a_full_zero, clk, rst_n, (out_valid && status == phq_pkg::ST_FULL) |-> (out_id == '0 && out_arrival == '0 && out_deadline == '0), "dropped push carries data")
    `PHQ_ASSERT(a_empty_occ, clk, rst_n, (out_valid && status == phq_pkg::ST_EMPTY) |-> (occupancy == '0), "empty pop with nonzero occupancy")
    `PHQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && !in_stall, in_stall, "input taken twice in a row")

endmodule
`default_nettype wire

@@ test/tb_priority_heap_queue.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for priority_heap_queue: min-heap push/pop in fifo and deadline modes.
// Depends on phq_pkg and the priority_heap_queue RTL; holds its own heap predictor.
module tb_priority_heap_queue;

    localparam int HEAP_DEPTH  = phq_pkg::DEPTH_DEF;
    localparam int ID_W        = phq_pkg::ID_W;
    localparam int PORT_W      = phq_pkg::PORT_W;
    localparam int OCC_W       = phq_pkg::OCC_W;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 600000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic                cfg_data     = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                kind         = phq_pkg::KIND_PUSH;
    logic [ID_W-1:0]     request_id   = '0;
    logic [PORT_W-1:0]   req_arrival  = '0;
    logic [PORT_W-1:0]   deadline     = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [1:0]          status;
    logic [ID_W-1:0]     out_id;
    logic [PORT_W-1:0]   out_arrival;
    logic [PORT_W-1:0]   out_deadline;
    logic [OCC_W-1:0]    occupancy;

    // heap predictor state
    logic [ID_W-1:0]     slot_id_q  [HEAP_DEPTH];
    logic [PORT_W-1:0]   slot_arr_q [HEAP_DEPTH];
    logic [PORT_W-1:0]   slot_dl_q  [HEAP_DEPTH];
    int                  heap_count = 0;
    logic                heap_mode  = phq_pkg::MODE_FIFO;

    phq_pkg::result_t    pending_results[$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    bit                  quiet_mode  = 1'b0;
    int                  stall_hold  = 0;

    priority_heap_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .request_id   (request_id),
        .req_arrival  (req_arrival),
        .deadline     (deadline),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_id       (out_id),
        .out_arrival  (out_arrival),
        .out_deadline (out_deadline),
        .occupancy    (occupancy)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("priority_heap_queue test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PORT_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return PORT_W'($urandom_range(0, 7));
        if (r == 5)
            return 32'hFFFF_FFF0 + PORT_W'($urandom_range(0, 15));
        return PORT_W'($urandom);
    endfunction

    function automatic logic slot_less(int a, int b);
        if (heap_mode == phq_pkg::MODE_FIFO)
            return slot_arr_q[a] < slot_arr_q[b];
        return slot_dl_q[a] < slot_dl_q[b];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [ID_W-1:0]   ti;
        logic [PORT_W-1:0] ta;
        logic [PORT_W-1:0] td;
        ti = slot_id_q[a];
        ta = slot_arr_q[a];
        td = slot_dl_q[a];
        slot_id_q[a]  = slot_id_q[b];
        slot_arr_q[a] = slot_arr_q[b];
        slot_dl_q[a]  = slot_dl_q[b];
        slot_id_q[b]  = ti;
        slot_arr_q[b] = ta;
        slot_dl_q[b]  = td;
    endfunction

    function automatic phq_pkg::result_t predict_heap_op(logic k, logic [ID_W-1:0] id,
                                                         logic [PORT_W-1:0] arr,
                                                         logic [PORT_W-1:0] dl);
        phq_pkg::result_t r;
        int      pos;
        int      up;
        int      best;
        int      last;
        bit      settled;
        r = '0;
        r.status = phq_pkg::ST_DONE;
        if (k == phq_pkg::KIND_PUSH)
        begin
            if (heap_count >= HEAP_DEPTH)
                r.status = phq_pkg::ST_FULL;
            else
            begin
                pos = heap_count;
                slot_id_q[pos]  = id;
                slot_arr_q[pos] = arr;
                slot_dl_q[pos]  = dl;
                heap_count = heap_count + 1;
                settled = 1'b0;
                while (pos > 0 && !settled)
                begin
                    up = (pos - 1) / 2;
                    if (slot_less(pos, up))
                    begin
                        swap_slots(pos, up);
                        pos = up;
                    end
                    else
                        settled = 1'b1;
                end
            end
        end
        else if (heap_count == 0)
            r.status = phq_pkg::ST_EMPTY;
        else
        begin
            last = heap_count - 1;
            r.id       = slot_id_q[0];
            r.arrival  = slot_arr_q[0];
            r.deadline = slot_dl_q[0];
            slot_id_q[0]  = slot_id_q[last];
            slot_arr_q[0] = slot_arr_q[last];
            slot_dl_q[0]  = slot_dl_q[last];
            heap_count = last;
            pos = 0;
            settled = 1'b0;
            while (pos < heap_count && !settled)
            begin
                best = pos;
                if (2 * pos + 1 < heap_count && slot_less(2 * pos + 1, best))
                    best = 2 * pos + 1;
                if (2 * pos + 2 < heap_count && slot_less(2 * pos + 2, best))
                    best = 2 * pos + 2;
                if (best == pos)
                    settled = 1'b1;
                else
                begin
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.occupancy = OCC_W'(heap_count);
        return r;
    endfunction

    // call at a rising edge; returns at the rising edge of the transfer or after the gap
    task automatic send_item(logic k, logic [ID_W-1:0] id, logic [PORT_W-1:0] arr,
                             logic [PORT_W-1:0] dl);
        logic stalled;
        int   g;
        in_valid     <= 1'b1;
        kind         <= k;
        request_id   <= id;
        req_arrival  <= arr;
        deadline     <= dl;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        pending_results.push_back(predict_heap_op(k, id, arr, dl));
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_order_mode(logic m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        heap_mode = m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        quiet_mode = 1'b1;
        set_order_mode(phq_pkg::MODE_FIFO);
        send_item(phq_pkg::KIND_POP, 8'h00, '0, '0);
        send_item(phq_pkg::KIND_PUSH, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(phq_pkg::KIND_PUSH, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(phq_pkg::KIND_PUSH, 8'hA5, 32'd5, 32'd5);
        send_item(phq_pkg::KIND_PUSH, 8'h5A, 32'd5, 32'd5);
        send_item(phq_pkg::KIND_PUSH, 8'h01, 32'd5, 32'd3);
        repeat (5) send_item(phq_pkg::KIND_POP, 8'hFF, '1, '1);
        send_item(phq_pkg::KIND_POP, 8'h00, '0, '0);
        wait_idle();
        set_order_mode(phq_pkg::MODE_EDF);
        send_item(phq_pkg::KIND_PUSH, 8'd10, 32'd0, 32'd100);
        send_item(phq_pkg::KIND_PUSH, 8'd11, 32'd1, 32'd100);
        send_item(phq_pkg::KIND_PUSH, 8'd12, 32'd2, 32'd0);
        send_item(phq_pkg::KIND_PUSH, 8'd13, 32'd3, 32'hFFFF_FFFF);
        repeat (5) send_item(phq_pkg::KIND_POP, 8'h00, '0, '0);
        wait_idle();
        quiet_mode = 1'b0;
    endtask

    task automatic test_fill_drain(logic m);
        wait_idle();
        set_order_mode(m);
        while (heap_count < HEAP_DEPTH)
            send_item(phq_pkg::KIND_PUSH, ID_W'($urandom), pick_stamp(), pick_stamp());
        repeat (3)
            send_item(phq_pkg::KIND_PUSH, ID_W'($urandom), pick_stamp(), pick_stamp());
        while (heap_count > 0)
            send_item(phq_pkg::KIND_POP, ID_W'($urandom), PORT_W'($urandom),
                      PORT_W'($urandom));
        send_item(phq_pkg::KIND_POP, ID_W'($urandom), PORT_W'($urandom), PORT_W'($urandom));
    endtask

    // mode changes land while entries are held, as the phases do not drain
    task automatic test_random_mix(int phases, int per_phase);
        int   push_pct;
        logic m;
        for (int p = 0; p < phases; p++)
        begin
            wait_idle();
            m = (p < 2) ? p[0] : logic'($urandom_range(0, 1));
            set_order_mode(m);
            case ($urandom_range(0, 3))
                0: push_pct = 30;
                1: push_pct = 50;
                2: push_pct = 70;
                default: push_pct = 90;
            endcase
            quiet_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < per_phase; i++)
                send_item(($urandom_range(0, 99) < push_pct) ? phq_pkg::KIND_PUSH
                                                              : phq_pkg::KIND_POP,
                          ID_W'($urandom), pick_stamp(), pick_stamp());
        end
        quiet_mode = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (quiet_mode)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 40)
        begin
            out_stall  <= 1'b1;
            stall_hold <= gap_len();
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 8);
        end
    end

    // result check: a transfer happens at the next rising edge
    always @(negedge clk)
    begin : check_results
        phq_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: status %0d id %0d", status, out_id);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    error_count++;
                end
                if (out_id !== want.id)
                begin
                    $error("out_id expected %0d actual %0d", want.id, out_id);
                    error_count++;
                end
                if (out_arrival !== want.arrival)
                begin
                    $error("out_arrival expected %0h actual %0h", want.arrival, out_arrival);
                    error_count++;
                end
                if (out_deadline !== want.deadline)
                begin
                    $error("out_deadline expected %0h actual %0h", want.deadline,
                           out_deadline);
                    error_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy expected %0d actual %0d", want.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_drain(phq_pkg::MODE_EDF);
        test_fill_drain(phq_pkg::MODE_FIFO);
        test_random_mix(12, 50);
        wait_idle();
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("priority_heap_queue test passed");
        else
            $display("priority_heap_queue test failed");
        $finish;
    end

endmodule
